@@ rtl/elfr_pkg.sv @@
// Package for the escaped length frame receiver.
// Holds receiver phase codes, register indexes and the frame-done record.
// No dependencies.
`timescale 1ns / 1ps

package elfr_pkg;

  localparam logic [7:0] ESC_BYTE = 8'h10;
  localparam int unsigned LEN_W = 7;
  localparam int unsigned CFG_IDX_W = 1;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_RUN  = 2'd1,
    PH_ESC  = 2'd2
  } phase_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_VALUE   = 1'b0,
    CFG_LENGTH_OFFSET = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic             valid;
    logic [LEN_W-1:0] len;
  } done_t;

endpackage

@@ rtl/elfr_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module elfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/elfr_rx.sv @@
// Receive side: phase tracking, escape handling, fill count and length capture.
// Writes bytes into the frame store and flags completed frames. Uses elfr_pkg.
`timescale 1ns / 1ps

module elfr_rx #(
  parameter int unsigned FRAME_BYTES = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_fire_i,
  input  logic [7:0]                         rx_byte_i,
  input  logic [7:0]                         start_value_i,
  input  logic [4:0]                         length_offset_i,
  output logic                               we_o,
  output logic [$clog2(FRAME_BYTES)-1:0]     waddr_o,
  output logic [7:0]                         wdata_o,
  output elfr_pkg::done_t                    done_o
);

  import elfr_pkg::*;

  localparam int unsigned AW = $clog2(FRAME_BYTES);
  localparam int unsigned CW = $clog2(FRAME_BYTES + 1);
  localparam logic [7:0] FB8 = 8'(FRAME_BYTES);
  localparam logic [CW-1:0] FULL_CNT = CW'(FRAME_BYTES);

  phase_e        phase_q, phase_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [7:0]    len_q, len_d;
  logic [CW-1:0] fill_inc;
  logic          full;
  logic          pos_hit;
  logic [7:0]    len_eff;

  assign fill_inc = fill_q + 1'b1;
  assign full     = (fill_q == FULL_CNT);
  assign pos_hit  = ({3'b000, length_offset_i} == 8'(fill_q));
  assign len_eff  = pos_hit ? rx_byte_i : len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      fill_q  <= '0;
      len_q   <= '0;
    end else begin
      phase_q <= phase_d;
      fill_q  <= fill_d;
      len_q   <= len_d;
    end
  end

  always_comb begin
    phase_d    = phase_q;
    fill_d     = fill_q;
    len_d      = len_q;
    we_o       = 1'b0;
    waddr_o    = fill_q[AW-1:0];
    wdata_o    = rx_byte_i;
    done_o     = '0;
    if (in_fire_i) begin
      unique case (phase_q)
        PH_RUN: begin
          if (rx_byte_i == ESC_BYTE) begin
            phase_d = PH_ESC;
          end else if (full) begin
            phase_d = PH_IDLE;
            fill_d  = '0;
          end else begin
            we_o   = 1'b1;
            fill_d = fill_inc;
            len_d  = len_eff;
            if (len_eff <= FB8 && 8'(fill_inc) == len_eff) begin
              done_o.valid = 1'b1;
              done_o.len   = LEN_W'(len_eff);
              phase_d      = PH_IDLE;
              fill_d       = '0;
            end
          end
        end
        PH_ESC: begin
          if (full) begin
            phase_d = PH_IDLE;
            fill_d  = '0;
          end else begin
            we_o    = 1'b1;
            fill_d  = fill_inc;
            len_d   = len_eff;
            phase_d = PH_RUN;
          end
        end
        default: begin
          if (rx_byte_i == start_value_i) begin
            we_o    = 1'b1;
            waddr_o = '0;
            fill_d  = CW'(1);
            phase_d = PH_RUN;
            len_d   = (length_offset_i == 5'd0) ? rx_byte_i : 8'h00;
          end else begin
            phase_d = PH_IDLE;
          end
        end
      endcase
    end
  end

endmodule

@@ rtl/elfr_rd.sv @@
// Readout side: walks the frame store after a completed frame and drives
// the output register with byte and last flag. Uses elfr_pkg.
`timescale 1ns / 1ps

module elfr_rd #(
  parameter int unsigned FRAME_BYTES = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  elfr_pkg::done_t                done_i,
  output logic                           re_o,
  output logic [$clog2(FRAME_BYTES)-1:0] raddr_o,
  input  logic [7:0]                     rdata_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic [7:0]                     frame_byte_o,
  output logic                           frame_last_o,
  output logic                           busy_o
);

  import elfr_pkg::*;

  localparam int unsigned AW = $clog2(FRAME_BYTES);

  logic             busy_q, busy_d;
  logic             pend_q, pend_d;
  logic             pend_last_q, pend_last_d;
  logic [LEN_W-1:0] cnt_q, cnt_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic             oval_q, oval_d;
  logic [7:0]       obyte_q, obyte_d;
  logic             olast_q, olast_d;
  logic [LEN_W-1:0] cnt_inc;
  logic             issue;

  assign cnt_inc = cnt_q + 1'b1;
  assign issue   = busy_q && (cnt_q != len_q) && !pend_q && (!oval_q || out_ready_i);
  assign re_o    = issue;
  assign raddr_o = cnt_q[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pend_q      <= 1'b0;
      pend_last_q <= 1'b0;
      cnt_q       <= '0;
      len_q       <= '0;
      oval_q      <= 1'b0;
      olast_q     <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      pend_q      <= pend_d;
      pend_last_q <= pend_last_d;
      cnt_q       <= cnt_d;
      len_q       <= len_d;
      oval_q      <= oval_d;
      olast_q     <= olast_d;
    end
  end

  always_ff @(posedge clk_i) begin
    obyte_q <= obyte_d;
  end

  always_comb begin
    busy_d      = busy_q;
    pend_d      = 1'b0;
    pend_last_d = pend_last_q;
    cnt_d       = cnt_q;
    len_d       = len_q;
    oval_d      = oval_q;
    obyte_d     = obyte_q;
    olast_d     = olast_q;
    if (oval_q && out_ready_i) begin
      oval_d = 1'b0;
    end
    if (pend_q) begin
      oval_d  = 1'b1;
      obyte_d = rdata_i;
      olast_d = pend_last_q;
      if (pend_last_q) begin
        busy_d = 1'b0;
      end
    end
    if (issue) begin
      pend_d      = 1'b1;
      pend_last_d = (cnt_inc == len_q);
      cnt_d       = cnt_inc;
    end
    if (done_i.valid) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      len_d  = done_i.len;
    end
  end

  assign out_valid_o  = oval_q;
  assign frame_byte_o = obyte_q;
  assign frame_last_o = olast_q;
  assign busy_o       = busy_q;

endmodule

@@ rtl/escaped_length_frame_receiver.sv @@
// Escaped length frame receiver: usage notes.
// Input channel (in_valid_i / in_ready_o / rx_byte_i) takes one received byte
// per transfer. While idle, a byte equal to start_value opens a frame; 0x10
// escapes the next byte; the byte at position length_offset gives the frame
// length. When the stored count reaches that length, the frame is read out
// of the store on the output channel (out_valid_o / out_ready_i) as
// frame_byte_o with frame_last_o on its final byte.
// Throughput: one input byte per cycle while a frame is being received.
// Readout: each byte is read from the store, then loaded into the single
// output register; a new read waits until no read is pending and the output
// register is empty or being taken. Input is held off from frame completion
// until the last byte has been read from the store; the last byte may then
// wait in the output register while new bytes are taken.
// A stalled receiver holds the output register and pauses readout.
// Configuration (cfg_valid_i / cfg_ready_o) is always ready; write only while
// idle. Reset returns to idle with start_value 1 and length_offset 1; the
// store needs no clearing pass.
// Depends on elfr_pkg, elfr_rx, elfr_rd and elfr_ram.
`timescale 1ns / 1ps

module escaped_length_frame_receiver #(
  parameter int unsigned FRAME_BYTES = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [7:0]                     rx_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [7:0]                     frame_byte_o,
  output logic                           frame_last_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [elfr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]                     cfg_data_i
);

  import elfr_pkg::*;

  localparam int unsigned AW = $clog2(FRAME_BYTES);

  logic [7:0]    start_q, start_d;
  logic [4:0]    loff_q, loff_d;
  logic          in_fire;
  logic          rd_busy;
  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic          re;
  logic [AW-1:0] raddr;
  logic [7:0]    rdata;
  done_t         done;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !rd_busy;
  assign in_fire     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 8'd1;
      loff_q  <= 5'd1;
    end else begin
      start_q <= start_d;
      loff_q  <= loff_d;
    end
  end

  always_comb begin
    start_d = start_q;
    loff_d  = loff_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_START_VALUE:   start_d = cfg_data_i;
        CFG_LENGTH_OFFSET: loff_d  = cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  elfr_rx #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_rx (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_fire_i      (in_fire),
    .rx_byte_i      (rx_byte_i),
    .start_value_i  (start_q),
    .length_offset_i(loff_q),
    .we_o           (we),
    .waddr_o        (waddr),
    .wdata_o        (wdata),
    .done_o         (done)
  );

  elfr_ram #(
    .WIDTH(8),
    .DEPTH(FRAME_BYTES)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  elfr_rd #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_rd (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .done_i      (done),
    .re_o        (re),
    .raddr_o     (raddr),
    .rdata_i     (rdata),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .frame_byte_o(frame_byte_o),
    .frame_last_o(frame_last_o),
    .busy_o      (rd_busy)
  );

endmodule

@@ rtl/elfr_chk.sv @@
// Port-level checker for the escaped length frame receiver, bound to the top.
// No dependencies beyond the top level's ports.
`timescale 1ns / 1ps

module elfr_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] frame_byte_o,
  input logic       frame_last_o,
  input logic       cfg_valid_i,
  input logic       cfg_ready_o
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(frame_byte_o) && $stable(frame_last_o))
    else $error("output changed while stalled");

  // Input is stalled while a frame is mid-readout.
  a_mid_frame_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !frame_last_o |-> !in_ready_o)
    else $error("input taken during frame readout");

  // Configuration writes are always taken.
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write stalled");

endmodule

bind escaped_length_frame_receiver elfr_chk u_chk (.*);

@@ bench/escaped_length_frame_receiver_tb.sv @@
// Self-checking bench for escaped_length_frame_receiver: escaped, length-prefixed frames
// with bursty input and a stalling output, checked against an in-bench frame predictor.
// Depends on elfr_pkg and the receiver RTL.
`timescale 1ns / 1ps

module escaped_length_frame_receiver_tb;
  import elfr_pkg::*;

  localparam int FRAME_BYTES    = 32;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS   = 330;
  localparam int PHASE_ITEMS    = 40;

  typedef struct packed {
    logic [7:0] data;
    logic       is_last;
  } frame_beat_t;

  typedef enum int {ESC_NEEDED, ESC_SOMETIMES, ESC_ALWAYS} esc_mode_e;

  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 in_valid_i   = 1'b0;
  logic                 in_ready_o;
  logic [7:0]           rx_byte_i    = 8'h00;
  logic                 out_valid_o;
  logic                 out_ready_i  = 1'b0;
  logic [7:0]           frame_byte_o;
  logic                 frame_last_o;
  logic                 cfg_valid_i  = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i  = CFG_START_VALUE;
  logic [7:0]           cfg_data_i   = 8'h00;

  // frame predictor state and its copy of the registers
  phase_e      rx_phase    = PH_IDLE;
  int          fill_cnt    = 0;
  logic [7:0]  frame_mem [FRAME_BYTES];
  logic [7:0]  start_cfg   = 8'd1;
  logic [4:0]  len_off_cfg = 5'd1;

  logic [7:0]  rx_pending [$];
  frame_beat_t frame_expect [$];
  int          mismatches  = 0;
  int          burst_left  = 0;
  int          gap_left    = 0;
  logic [11:0] stall_pat   = '1;
  int          stall_cnt   = 0;
  int          idle_cycles = 0;

  escaped_length_frame_receiver #(
    .FRAME_BYTES(FRAME_BYTES)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .rx_byte_i   (rx_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .frame_byte_o(frame_byte_o),
    .frame_last_o(frame_last_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    foreach (frame_mem[i]) frame_mem[i] = 8'h00;
  end

  function automatic void absorb_rx_byte(logic [7:0] b);
    int len;
    int i;
    case (rx_phase)
      PH_RUN: begin
        if (b == ESC_BYTE) begin
          rx_phase = PH_ESC;
        end else if (fill_cnt >= FRAME_BYTES) begin
          rx_phase = PH_IDLE;
          fill_cnt = 0;
        end else begin
          frame_mem[fill_cnt] = b;
          fill_cnt++;
          len = (len_off_cfg < FRAME_BYTES) ? int'(frame_mem[len_off_cfg]) : 0;
          if (len <= FRAME_BYTES && fill_cnt == len) begin
            for (i = 0; i < len; i++) frame_expect.push_back('{frame_mem[i], i == len - 1});
            rx_phase = PH_IDLE;
            fill_cnt = 0;
          end
        end
      end
      PH_ESC: begin
        if (fill_cnt >= FRAME_BYTES) begin
          rx_phase = PH_IDLE;
          fill_cnt = 0;
        end else begin
          frame_mem[fill_cnt] = b;
          fill_cnt++;
          rx_phase = PH_RUN;
        end
      end
      default: begin
        if (b == start_cfg) begin
          for (i = 0; i < FRAME_BYTES; i++) frame_mem[i] = 8'h00;
          frame_mem[0] = b;
          fill_cnt = 1;
          rx_phase = PH_RUN;
        end else begin
          rx_phase = PH_IDLE;
        end
      end
    endcase
  endfunction

  function automatic logic [7:0] pick_data();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return ESC_BYTE;
      3: return start_cfg;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void push_stored(logic [7:0] b, esc_mode_e mode);
    if (b == ESC_BYTE || mode == ESC_ALWAYS ||
        (mode == ESC_SOMETIMES && $urandom_range(0, 5) == 0))
      rx_pending.push_back(ESC_BYTE);
    rx_pending.push_back(b);
  endfunction

  function automatic int queue_good_frame(bit esc_last);
    int len;
    int p;
    int n0;
    logic [7:0] b;
    n0 = rx_pending.size();
    if (len_off_cfg == 0)
      len = start_cfg;
    else if ($urandom_range(0, 7) == 0)
      len = $urandom_range(len_off_cfg + 1, FRAME_BYTES);
    else
      len = len_off_cfg + 1 + $urandom_range(0, (len_off_cfg > 26) ? 31 - len_off_cfg : 5);
    if (len == ESC_BYTE && len_off_cfg == len - 1) len++;
    rx_pending.push_back(start_cfg);
    for (p = 1; p < len; p++) begin
      b = (p == len_off_cfg) ? 8'(len) : pick_data();
      if (p == len - 1) begin
        if (b == ESC_BYTE && !esc_last) b = 8'h11;
        push_stored(b, esc_last ? ESC_ALWAYS : ESC_NEEDED);
      end else begin
        push_stored(b, ESC_SOMETIMES);
      end
    end
    return rx_pending.size() - n0;
  endfunction

  function automatic int queue_overrun();
    int p;
    int n0;
    logic [7:0] b;
    n0 = rx_pending.size();
    rx_pending.push_back(start_cfg);
    for (p = 1; p < FRAME_BYTES; p++) begin
      if (p == len_off_cfg) begin
        case ($urandom_range(0, 2))
          0: b = 8'h00;
          1: b = 8'($urandom_range(FRAME_BYTES + 1, 255));
          default: b = 8'($urandom_range(1, len_off_cfg));
        endcase
      end else begin
        b = pick_data();
      end
      push_stored(b, ESC_SOMETIMES);
    end
    // one byte past the full store
    rx_pending.push_back(pick_data());
    if (rx_pending[$] == ESC_BYTE) rx_pending.push_back(pick_data());
    return rx_pending.size() - n0;
  endfunction

  function automatic void queue_flush();
    logic [7:0] f;
    int p;
    f = start_cfg ^ 8'h5A;
    if (f == ESC_BYTE) f = f ^ 8'h01;
    for (p = 0; p < FRAME_BYTES + 2; p++) rx_pending.push_back(f);
  endfunction

  task automatic load_config(logic [7:0] start_val, logic [4:0] off);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_START_VALUE;
    cfg_data_i  <= start_val;
    do @(posedge clk_i); while (!cfg_ready_o);
    start_cfg = start_val;
    cfg_index_i <= CFG_LENGTH_OFFSET;
    cfg_data_i  <= {3'($urandom), off};
    do @(posedge clk_i); while (!cfg_ready_o);
    len_off_cfg = off;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (rx_pending.size() != 0 || in_valid_i || frame_expect.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // input driver: bursts with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      rx_byte_i  <= 8'h00;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        absorb_rx_byte(rx_byte_i);
        if (burst_left > 0) burst_left--;
      end
      if (!in_valid_i || in_ready_o) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (rx_pending.size() != 0) begin
          in_valid_i <= 1'b1;
          rx_byte_i  <= rx_pending.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // output stall pattern: a rotating 12-bit mask, reloaded when its counter runs out
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_pat = '1;
      stall_cnt = 0;
    end else begin
      if (stall_cnt == 0) begin
        stall_cnt = 96;
        stall_pat = ($urandom_range(0, 2) == 0) ? 12'hFFF : (12'($urandom) | 12'h001);
      end
      stall_cnt--;
      out_ready_i <= stall_pat[0];
      stall_pat = {stall_pat[0], stall_pat[11:1]};
    end
  end

  // output monitor
  always @(posedge clk_i) begin : frame_monitor
    frame_beat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (frame_expect.size() == 0) begin
        $error("unexpected frame byte transfer: frame_byte %02h frame_last %0b",
               frame_byte_o, frame_last_o);
        mismatches++;
      end else begin
        want = frame_expect.pop_front();
        if (frame_byte_o !== want.data) begin
          $error("frame_byte mismatch: expected %02h, actual %02h", want.data, frame_byte_o);
          mismatches++;
        end
        if (frame_last_o !== want.is_last) begin
          $error("frame_last mismatch: expected %0b, actual %0b", want.is_last, frame_last_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("escaped_length_frame_receiver regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int          frame_items;
    int          phase_items;
    int          ph;
    int          r;
    int          n;
    bit          can_close;
    logic [7:0]  s_new;
    logic [4:0]  k_new;
    logic [7:0]  b;
    frame_items = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // ignored idle bytes, shortest frame, escaped escape, escaped data and start value as data
    rx_pending = '{8'h00, 8'hFF, ESC_BYTE,
                   8'h01, 8'h02,
                   8'h01, 8'h04, ESC_BYTE, ESC_BYTE, 8'hFF,
                   8'h01, 8'h05, ESC_BYTE, 8'hAA, 8'h5A, 8'h01};
    wait_drained();

    ph = 0;
    while (frame_items < RANDOM_ITEMS) begin
      case (ph)
        0: begin s_new = 8'h00; k_new = 5'd31; end
        1: begin s_new = 8'h20; k_new = 5'd0; end
        2: begin s_new = ESC_BYTE; k_new = 5'd1; end
        3: begin s_new = 8'hFF; k_new = 5'd2; end
        default: begin
          case ($urandom_range(0, 5))
            0: s_new = 8'h00;
            1: s_new = 8'hFF;
            2: s_new = ESC_BYTE;
            default: s_new = 8'($urandom);
          endcase
          k_new = ($urandom_range(0, 4) == 0) ? 5'($urandom) : 5'($urandom_range(1, 4));
        end
      endcase
      load_config(s_new, k_new);
      can_close = (len_off_cfg != 0) || (start_cfg >= 2 && start_cfg <= FRAME_BYTES);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS && frame_items + phase_items < RANDOM_ITEMS) begin
        if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, 3)) begin
            b = 8'($urandom);
            if (b == start_cfg) b = b ^ 8'h01;
            rx_pending.push_back(b);
          end
        end
        r = $urandom_range(0, 99);
        if (r < 72 && can_close) begin
          void'(queue_good_frame(1'b0));
        end else if (r < 91 && r >= 82 && can_close) begin
          void'(queue_good_frame(1'b1));
          queue_flush();
        end else if (r >= 91 && can_close) begin
          n = queue_good_frame(1'b0);
          r = $urandom_range(1, n - 1);
          repeat (r) void'(rx_pending.pop_back());
          queue_flush();
        end else begin
          void'(queue_overrun());
          queue_flush();
        end
        phase_items = rx_pending.size();
      end
      frame_items += phase_items;
      wait_drained();
      ph++;
    end

    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && frame_expect.size() == 0)
      $display("escaped_length_frame_receiver regression: pass");
    else
      $display("escaped_length_frame_receiver regression: fail");
    $finish;
  end

endmodule

@@ escaped_length_frame_receiver.f @@
rtl/elfr_pkg.sv
rtl/elfr_ram.sv
rtl/elfr_rx.sv
rtl/elfr_rd.sv
rtl/escaped_length_frame_receiver.sv
rtl/elfr_chk.sv
bench/escaped_length_frame_receiver_tb.sv
